FILE: rtl/lzbd_pkg.sv
// Package for the LZSS bit-packed decoder.
// Holds default parameters, constants, the control state type and shared structs.
// No dependencies.
`timescale 1ns / 1ps

package lzbd_pkg;

    localparam int WINDOW_BITS_DEF = 12;
    localparam int LENGTH_BITS_DEF = 4;
    localparam int LOOKAHEAD_DEF   = 17;

    localparam logic [7:0] SPACE_BYTE = 8'h20;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       done;
    } emit_t;

    typedef struct packed {
        logic empty;
        logic lit_ready;
        logic match_ready;
    } tok_stat_t;

endpackage

FILE: rtl/lzbd_in_if.sv
// Input channel interface of the LZSS decoder: one compressed byte per item.
// Depends on nothing.
`timescale 1ns / 1ps

interface lzbd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] code_byte;

    modport source (output valid, output code_byte, input ready);
    modport sink (input valid, input code_byte, output ready);
endinterface

FILE: rtl/lzbd_out_if.sv
// Output channel interface of the LZSS decoder: one decompressed byte per item.
// Depends on nothing.
`timescale 1ns / 1ps

interface lzbd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       stream_done;

    modport source (output valid, output out_byte, output last_of_run, output stream_done,
                    input ready);
    modport sink (input valid, input out_byte, input last_of_run, input stream_done,
                  output ready);
endinterface

FILE: rtl/lzbd_token.sv
// Bit-serial token assembler: shifts a code byte out one bit per cycle while step is
// asserted and collects flag, literal and match fields. Depends on lzbd_pkg.
`timescale 1ns / 1ps

module lzbd_token #(
    parameter int WINDOW_BITS = lzbd_pkg::WINDOW_BITS_DEF,
    parameter int LENGTH_BITS = lzbd_pkg::LENGTH_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  logic [7:0]             load_byte,
    input  logic                   step,
    input  logic                   clear,
    output lzbd_pkg::tok_stat_t    stat,
    output logic [7:0]             lit_byte,
    output logic [WINDOW_BITS-1:0] match_pos,
    output logic [LENGTH_BITS-1:0] match_len
);

    localparam int MATCH_BITS = 1 + WINDOW_BITS + LENGTH_BITS;
    localparam int FIELD_BITS = MATCH_BITS - 1;
    localparam int CW         = $clog2(MATCH_BITS);

    logic [7:0]            byte_sr_reg;
    logic [3:0]            left_reg;
    logic                  flag_reg;
    logic [CW-1:0]         cnt_reg;
    logic [FIELD_BITS-1:0] field_reg;
    logic                  bit_in;
    logic [FIELD_BITS-1:0] field_next;

    assign bit_in     = byte_sr_reg[7];
    assign field_next = {field_reg[FIELD_BITS-2:0], bit_in};

    assign stat.empty       = (left_reg == 4'd0);
    assign stat.lit_ready   = (cnt_reg == CW'(8)) && flag_reg;
    assign stat.match_ready = (cnt_reg == CW'(FIELD_BITS)) && !flag_reg;

    assign lit_byte  = field_next[7:0];
    assign match_pos = field_next[FIELD_BITS-1:LENGTH_BITS];
    assign match_len = field_next[LENGTH_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= 4'd0;
            cnt_reg  <= '0;
            flag_reg <= 1'b0;
        end
        else if (clear)
        begin
            left_reg <= 4'd0;
            cnt_reg  <= '0;
        end
        else if (load)
        begin
            left_reg <= 4'd8;
        end
        else if (step)
        begin
            left_reg <= left_reg - 4'd1;
            if (cnt_reg == '0)
            begin
                flag_reg <= bit_in;
                cnt_reg  <= CW'(1);
            end
            else if (stat.lit_ready || stat.match_ready)
            begin
                cnt_reg <= '0;
            end
            else
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_sr_reg <= load_byte;
        end
        else if (step)
        begin
            byte_sr_reg <= {byte_sr_reg[6:0], 1'b0};
            field_reg   <= field_next;
        end
    end

endmodule

FILE: rtl/lzbd_window.sv
// History window of the LZSS decoder: a memory with write pointer and a fill
// count that makes unwritten entries read as spaces. Depends on lzbd_pkg.
`timescale 1ns / 1ps

module lzbd_window #(
    parameter int WINDOW_BITS = lzbd_pkg::WINDOW_BITS_DEF,
    parameter int LOOKAHEAD   = lzbd_pkg::LOOKAHEAD_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  logic [7:0]             wr_data,
    input  logic                   rd_en,
    input  logic [WINDOW_BITS-1:0] rd_addr,
    output logic [7:0]             rd_byte
);

    localparam int                   DEPTH   = 1 << WINDOW_BITS;
    localparam logic [WINDOW_BITS-1:0] WP_INIT = WINDOW_BITS'(DEPTH - LOOKAHEAD);

    logic [7:0]             mem [0:DEPTH-1];
    logic [WINDOW_BITS-1:0] wp_reg;
    logic [WINDOW_BITS:0]   fill_reg;
    logic [7:0]             rd_data_reg;
    logic                   rd_ok_reg;
    logic [WINDOW_BITS-1:0] rd_offset;

    // Entries are written in pointer order from the reset pointer, so an entry
    // holds data exactly when its offset from there is below the fill count.
    assign rd_offset = rd_addr - WP_INIT;
    assign rd_byte   = rd_ok_reg ? rd_data_reg : lzbd_pkg::SPACE_BYTE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= WP_INIT;
            fill_reg  <= '0;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                wp_reg <= wp_reg + WINDOW_BITS'(1);
                if (!fill_reg[WINDOW_BITS])
                begin
                    fill_reg <= fill_reg + (WINDOW_BITS+1)'(1);
                end
            end
            if (rd_en)
            begin
                rd_ok_reg <= ({1'b0, rd_offset} < fill_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wp_reg] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/lzbd_out_stage.sv
// Output stage of the LZSS decoder: holds one pending byte until it is known
// whether it ends its run, then moves it into the output register.
// Depends on lzbd_pkg and lzbd_out_if.
`timescale 1ns / 1ps

module lzbd_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  lzbd_pkg::emit_t   emit,
    input  logic              flush,
    output logic              room,
    lzbd_out_if.source        data_out
);

    logic       pend_v_reg;
    logic [7:0] pend_data_reg;
    logic       pend_done_reg;
    logic       ov_reg;
    logic [7:0] out_data_reg;
    logic       out_last_reg;
    logic       out_done_reg;
    logic       slot_free;
    logic       move;

    assign slot_free = !ov_reg || data_out.ready;
    assign room      = !pend_v_reg || slot_free;
    assign move      = pend_v_reg && (emit.valid || flush) && slot_free;

    assign data_out.valid       = ov_reg;
    assign data_out.out_byte    = out_data_reg;
    assign data_out.last_of_run = out_last_reg;
    assign data_out.stream_done = out_done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_v_reg <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            if (move)
            begin
                ov_reg <= 1'b1;
            end
            else if (data_out.ready)
            begin
                ov_reg <= 1'b0;
            end
            if (emit.valid && room)
            begin
                pend_v_reg <= 1'b1;
            end
            else if (flush && room)
            begin
                pend_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            out_data_reg <= pend_data_reg;
            out_done_reg <= pend_done_reg;
            out_last_reg <= flush;
        end
        if (emit.valid && room)
        begin
            pend_data_reg <= emit.data;
            pend_done_reg <= emit.done;
        end
    end

endmodule

FILE: rtl/lzss_bit_packed_decoder_top.sv
// Top level of the LZSS bit-packed decoder with its control sequencer.
// Depends on lzbd_pkg, lzbd_in_if, lzbd_out_if, lzbd_token, lzbd_window and lzbd_out_stage.
`timescale 1ns / 1ps

// The decoder takes one compressed byte per item and walks through its bits one
// per cycle unless a match copy or an output stall holds it. Each input byte is
// taken, has its 8 bits stepped through, is found used up and has its run closed;
// each byte copied by a match needs a registered read of the history window
// before it is written back. A run closes early once the stream is complete.
// A decoded byte waits in the output stage until the next byte or the close of
// its run shows whether it ends the run, and is then moved into the output
// register that drives the port.
// Write total_length before sending data; once that many bytes are out, further
// items are taken and dropped until total_length is raised.
module lzss_bit_packed_decoder_top #(
    parameter int WINDOW_BITS = lzbd_pkg::WINDOW_BITS_DEF,
    parameter int LENGTH_BITS = lzbd_pkg::LENGTH_BITS_DEF,
    parameter int LOOKAHEAD   = lzbd_pkg::LOOKAHEAD_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    lzbd_in_if.sink     code_in,
    lzbd_out_if.source  data_out
);

    lzbd_pkg::state_t       state_reg;
    lzbd_pkg::state_t       state_next;
    logic [31:0]            total_reg;
    logic [31:0]            produced_reg;
    logic [WINDOW_BITS-1:0] pos_reg;
    logic [LENGTH_BITS:0]   rem_reg;

    lzbd_pkg::tok_stat_t    tok_stat;
    logic [7:0]             lit_byte;
    logic [WINDOW_BITS-1:0] match_pos;
    logic [LENGTH_BITS-1:0] match_len;
    logic [7:0]             win_byte;
    logic                   room;

    logic                   tok_load;
    logic                   tok_step;
    logic                   tok_clear;
    logic                   win_rd;
    logic                   match_take;
    logic                   copy_adv;
    logic                   flush;
    logic                   hit;
    lzbd_pkg::emit_t        emit;

    assign hit = ((produced_reg + 32'd1) == total_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= lzbd_pkg::ST_IDLE;
            total_reg    <= '0;
            produced_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                total_reg <= cfg_wr_data;
            end
            if (emit.valid)
            begin
                produced_reg <= produced_reg + 32'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (match_take)
        begin
            pos_reg <= match_pos;
            rem_reg <= {1'b0, match_len} + (LENGTH_BITS+1)'(2);
        end
        else if (copy_adv)
        begin
            pos_reg <= pos_reg + WINDOW_BITS'(1);
            rem_reg <= rem_reg - (LENGTH_BITS+1)'(1);
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        code_in.ready = 1'b0;
        tok_load      = 1'b0;
        tok_step      = 1'b0;
        tok_clear     = 1'b0;
        win_rd        = 1'b0;
        match_take    = 1'b0;
        copy_adv      = 1'b0;
        flush         = 1'b0;
        emit.valid    = 1'b0;
        emit.data     = lit_byte;
        emit.done     = hit;
        case (state_reg)
            lzbd_pkg::ST_IDLE:
            begin
                code_in.ready = 1'b1;
                if (code_in.valid && (produced_reg < total_reg))
                begin
                    tok_load   = 1'b1;
                    state_next = lzbd_pkg::ST_SHIFT;
                end
            end
            lzbd_pkg::ST_SHIFT:
            begin
                if (tok_stat.empty)
                begin
                    state_next = lzbd_pkg::ST_FLUSH;
                end
                else if (tok_stat.lit_ready)
                begin
                    if (room)
                    begin
                        tok_step   = 1'b1;
                        emit.valid = 1'b1;
                        if (hit)
                        begin
                            tok_clear  = 1'b1;
                            state_next = lzbd_pkg::ST_FLUSH;
                        end
                    end
                end
                else if (tok_stat.match_ready)
                begin
                    tok_step   = 1'b1;
                    match_take = 1'b1;
                    state_next = lzbd_pkg::ST_COPY_RD;
                end
                else
                begin
                    tok_step = 1'b1;
                end
            end
            lzbd_pkg::ST_COPY_RD:
            begin
                win_rd     = 1'b1;
                state_next = lzbd_pkg::ST_COPY_WR;
            end
            lzbd_pkg::ST_COPY_WR:
            begin
                emit.data = win_byte;
                if (room)
                begin
                    emit.valid = 1'b1;
                    copy_adv   = 1'b1;
                    if (hit)
                    begin
                        tok_clear  = 1'b1;
                        state_next = lzbd_pkg::ST_FLUSH;
                    end
                    else if (rem_reg == (LENGTH_BITS+1)'(1))
                    begin
                        state_next = lzbd_pkg::ST_SHIFT;
                    end
                    else
                    begin
                        state_next = lzbd_pkg::ST_COPY_RD;
                    end
                end
            end
            lzbd_pkg::ST_FLUSH:
            begin
                if (room)
                begin
                    flush      = 1'b1;
                    state_next = lzbd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lzbd_pkg::ST_IDLE;
            end
        endcase
    end

    lzbd_token #(
        .WINDOW_BITS (WINDOW_BITS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_token (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (tok_load),
        .load_byte (code_in.code_byte),
        .step      (tok_step),
        .clear     (tok_clear),
        .stat      (tok_stat),
        .lit_byte  (lit_byte),
        .match_pos (match_pos),
        .match_len (match_len)
    );

    lzbd_window #(
        .WINDOW_BITS (WINDOW_BITS),
        .LOOKAHEAD   (LOOKAHEAD)
    ) u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (emit.valid),
        .wr_data (emit.data),
        .rd_en   (win_rd),
        .rd_addr (pos_reg),
        .rd_byte (win_byte)
    );

    lzbd_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .emit     (emit),
        .flush    (flush),
        .room     (room),
        .data_out (data_out)
    );

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the LZSS bit-packed decoder top level.
// Drives compressed bytes and total_length settings, predicts every decoded byte.
// Depends on lzbd_pkg, lzbd_in_if, lzbd_out_if and lzss_bit_packed_decoder_top.
`timescale 1ns / 1ps

module testbench;

    localparam int WIN_BITS   = lzbd_pkg::WINDOW_BITS_DEF;
    localparam int LEN_BITS   = lzbd_pkg::LENGTH_BITS_DEF;
    localparam int WIN_SIZE   = 1 << WIN_BITS;
    localparam int LIT_WIDTH  = 9;
    localparam int TOK_WIDTH  = 1 + WIN_BITS + LEN_BITS;
    localparam int QUIET_GAP  = 64;
    localparam int CYCLE_CAP  = 600000;
    localparam int LIVE_ITEMS = 370;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       done;
    } out_item_t;

    typedef enum logic {
        ROW_CFG,
        ROW_CODE
    } row_op_t;

    typedef struct packed {
        row_op_t     op;
        logic [31:0] value;
        logic        typed;
        out_item_t   want;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic [31:0] cfg_wr_data;

    lzbd_in_if  code_in ();
    lzbd_out_if data_out ();

    lzss_bit_packed_decoder_top u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .code_in     (code_in),
        .data_out    (data_out)
    );

    always #6 clk = ~clk;

    logic [7:0]          hist [0:WIN_SIZE-1];
    logic [WIN_BITS-1:0] wr_ptr;
    logic [31:0]         bit_buf;
    int                  bit_cnt;
    logic [31:0]         produced;
    logic [31:0]         total_len;

    out_item_t decoded_q [$];
    out_item_t step_out [$];
    bit        gen_bits [$];

    int  errors = 0;
    int  cycles = 0;
    int  bytes_in = 0;
    int  bytes_out = 0;
    int  live_items = 0;
    int  cfg_writes = 0;
    int  phases = 0;
    bit  steady = 1'b0;
    out_item_t got_item;
    out_item_t want_item;

    // The first rows walk literals, an overlapping match and a truncated match.
    dir_row_t directed_rows [0:15] = '{
        '{ROW_CODE, 32'h5A, 1'b0, '0},
        '{ROW_CFG,  32'd2,  1'b0, '0},
        '{ROW_CODE, 32'h80, 1'b0, '0},
        '{ROW_CODE, 32'h7F, 1'b1, '{8'h00, 1'b1, 1'b0}},
        '{ROW_CODE, 32'hC0, 1'b1, '{8'hFF, 1'b1, 1'b1}},
        '{ROW_CODE, 32'hFF, 1'b0, '0},
        '{ROW_CFG,  32'd20, 1'b0, '0},
        '{ROW_CODE, 32'h7F, 1'b0, '0},
        '{ROW_CODE, 32'h7F, 1'b0, '0},
        '{ROW_CODE, 32'hD5, 1'b0, '0},
        '{ROW_CODE, 32'h40, 1'b0, '0},
        '{ROW_CFG,  32'd25, 1'b0, '0},
        '{ROW_CODE, 32'h00, 1'b0, '0},
        '{ROW_CODE, 32'h07, 1'b0, '0},
        '{ROW_CODE, 32'hB3, 1'b0, '0},
        '{ROW_CODE, 32'h00, 1'b0, '0}
    };

    function automatic logic [15:0] pull_bits(input int n);
        logic [31:0] v;
        v = (bit_buf >> (bit_cnt - n)) & ((32'd1 << n) - 32'd1);
        bit_cnt = bit_cnt - n;
        bit_buf = bit_buf & ((32'd1 << bit_cnt) - 32'd1);
        return v[15:0];
    endfunction

    function automatic void emit_byte(input logic [7:0] b);
        hist[wr_ptr] = b;
        wr_ptr = wr_ptr + 1'b1;
        produced = produced + 32'd1;
        step_out.push_back('{data: b, last: 1'b0, done: (produced == total_len)});
    endfunction

    function automatic bit decode_code_byte(input logic [7:0] cb);
        logic [15:0]         field;
        logic [WIN_BITS-1:0] pos;
        logic [WIN_BITS-1:0] idx;
        int                  cnt;
        int                  k;
        step_out.delete();
        if (produced >= total_len)
            return 1'b1;
        bit_buf = (bit_buf << 8) | {24'd0, cb};
        bit_cnt = bit_cnt + 8;
        while (produced < total_len && bit_cnt >= 1) begin
            if (bit_buf[bit_cnt-1]) begin
                if (bit_cnt < LIT_WIDTH)
                    break;
                field = pull_bits(1);
                field = pull_bits(8);
                emit_byte(field[7:0]);
            end
            else begin
                if (bit_cnt < TOK_WIDTH)
                    break;
                field = pull_bits(1);
                field = pull_bits(WIN_BITS);
                pos = field[WIN_BITS-1:0];
                field = pull_bits(LEN_BITS);
                cnt = int'(field) + 2;
                for (k = 0; k < cnt && produced < total_len; k++) begin
                    idx = pos + k[WIN_BITS-1:0];
                    emit_byte(hist[idx]);
                end
            end
        end
        if (produced >= total_len) begin
            bit_buf = '0;
            bit_cnt = 0;
        end
        if (step_out.size() > 0)
            step_out[step_out.size()-1].last = 1'b1;
        return 1'b0;
    endfunction

    function automatic bit take_gap();
        return !steady && ($urandom_range(0, 99) < 22);
    endfunction

    function automatic void push_field(input logic [15:0] v, input int w);
        for (int j = w - 1; j >= 0; j--)
            gen_bits.push_back(v[j]);
    endfunction

    function automatic void report_mismatch(input string what, input logic [7:0] exp_v,
                                            input logic [7:0] got_v);
        errors++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, exp_v, got_v);
    endfunction

    task automatic send_code(input logic [7:0] b, input logic typed, input out_item_t want);
        bit ignored;
        while (take_gap()) begin
            code_in.valid <= 1'b0;
            @(posedge clk);
        end
        code_in.valid     <= 1'b1;
        code_in.code_byte <= b;
        do @(posedge clk); while (code_in.ready !== 1'b1);
        bytes_in++;
        ignored = decode_code_byte(b);
        if (!ignored)
            live_items++;
        if (typed)
            decoded_q.push_back(want);
        else
            foreach (step_out[i])
                decoded_q.push_back(step_out[i]);
    endtask

    task automatic wait_quiet();
        code_in.valid <= 1'b0;
        @(posedge clk);
        while (decoded_q.size() != 0)
            @(posedge clk);
        repeat (QUIET_GAP) @(posedge clk);
    endtask

    task automatic write_total(input logic [31:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        total_len = v;
        cfg_writes++;
    endtask

    task automatic token_phase(input int want_len, input bit to_max, input bit hold_mid);
        int                  made;
        int                  len;
        int                  nb;
        logic [WIN_BITS-1:0] ptr;
        logic [WIN_BITS-1:0] pos;
        logic [7:0]          lit;
        logic [7:0]          cb;
        gen_bits.delete();
        made = 0;
        ptr  = wr_ptr;
        while (made < want_len) begin
            if ($urandom_range(0, 1) == 1) begin
                case ($urandom_range(0, 7))
                    0: lit = 8'h00;
                    1: lit = 8'hFF;
                    default: lit = 8'($urandom_range(0, 255));
                endcase
                push_field(16'd1, 1);
                push_field({8'd0, lit}, 8);
                made++;
                ptr = ptr + 1'b1;
            end
            else begin
                case ($urandom_range(0, 3))
                    0: pos = WIN_BITS'($urandom);
                    1: pos = ptr - WIN_BITS'($urandom_range(1, 18));
                    2: pos = ($urandom_range(0, 1) == 1) ? '0 : '1;
                    default: pos = ptr - WIN_BITS'($urandom_range(1, 300));
                endcase
                len = $urandom_range(0, (1 << LEN_BITS) - 1);
                push_field(16'd0, 1);
                push_field(16'(pos), WIN_BITS);
                push_field(16'(len), LEN_BITS);
                made += len + 2;
                ptr = ptr + WIN_BITS'(len + 2);
            end
        end
        while (gen_bits.size() % 8 != 0)
            gen_bits.push_back(1'($urandom_range(0, 1)));
        wait_quiet();
        write_total(to_max ? 32'hFFFF_FFFF : produced + 32'(want_len));
        phases++;
        nb = gen_bits.size() / 8;
        for (int i = 0; i < nb; i++) begin
            if (hold_mid && i == nb / 2) begin
                code_in.valid <= 1'b0;
                @(posedge clk);
                while (decoded_q.size() != 0)
                    @(posedge clk);
            end
            cb = '0;
            for (int j = 0; j < 8; j++)
                cb = {cb[6:0], gen_bits[8*i+j]};
            send_code(cb, 1'b0, '0);
        end
        if (!to_max)
            repeat ($urandom_range(0, 2)) send_code(8'($urandom_range(0, 255)), 1'b0, '0);
    endtask

    task automatic noise_phase();
        int n;
        wait_quiet();
        write_total(produced + 32'($urandom_range(4, 40)));
        phases++;
        n = 0;
        while (produced < total_len && n < 300) begin
            send_code(8'($urandom_range(0, 255)), 1'b0, '0);
            n++;
        end
    endtask

    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_CAP) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        data_out.ready = 1'b0;
        forever begin
            @(posedge clk);
            data_out.ready <= !take_gap();
        end
    end

    always @(posedge clk) begin
        if (rst_n === 1'b1 && data_out.valid === 1'b1 && data_out.ready === 1'b1) begin
            got_item = '{data_out.out_byte, data_out.last_of_run, data_out.stream_done};
            bytes_out++;
            if (decoded_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected output byte %0h", $time, got_item.data);
            end
            else begin
                want_item = decoded_q.pop_front();
                if (got_item.data !== want_item.data)
                    report_mismatch("out_byte", want_item.data, got_item.data);
                if (got_item.last !== want_item.last)
                    report_mismatch("last_of_run", 8'(want_item.last), 8'(got_item.last));
                if (got_item.done !== want_item.done)
                    report_mismatch("stream_done", 8'(want_item.done), 8'(got_item.done));
            end
        end
    end

    initial begin
        int pass_idx;
        rst_n             = 1'b0;
        cfg_wr_en         = 1'b0;
        cfg_wr_data       = '0;
        code_in.valid     = 1'b0;
        code_in.code_byte = '0;
        for (int i = 0; i < WIN_SIZE; i++)
            hist[i] = lzbd_pkg::SPACE_BYTE;
        wr_ptr    = WIN_BITS'(WIN_SIZE - lzbd_pkg::LOOKAHEAD_DEF);
        bit_buf   = '0;
        bit_cnt   = 0;
        produced  = '0;
        total_len = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].op == ROW_CFG) begin
                wait_quiet();
                write_total(directed_rows[i].value);
            end
            else begin
                send_code(directed_rows[i].value[7:0], directed_rows[i].typed,
                          directed_rows[i].want);
            end
        end

        live_items = 0;
        pass_idx   = 0;
        while (live_items < LIVE_ITEMS) begin
            steady = (pass_idx >= 4 && pass_idx < 8);
            if ($urandom_range(0, 4) == 0)
                noise_phase();
            else
                token_phase($urandom_range(8, 60), 1'b0, pass_idx == 2);
            pass_idx++;
        end
        steady = 1'b0;

        // An unreachable total keeps the stream open; pulling the total back closes it.
        token_phase(40, 1'b1, 1'b0);
        wait_quiet();
        write_total(produced);
        repeat (2) send_code(8'($urandom_range(0, 255)), 1'b0, '0);
        wait_quiet();

        if (decoded_q.size() != 0) begin
            errors++;
            $display("%0t: %0d expected bytes never came out", $time, decoded_q.size());
        end
        $display("Sent %0d compressed bytes over %0d stream phases and %0d total_length writes.",
                 bytes_in, phases, cfg_writes);
        $display("Checked %0d decoded bytes with their run and stream end flags.", bytes_out);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
